FILE: rtl/swfd_pkg.sv
package swfd_pkg;

   // Frame geometry
   localparam int ULTRA_PAYLOAD = 8;
   localparam int ODOM_PAYLOAD  = 4;
   localparam int ULTRA_CNT_W   = $clog2(ULTRA_PAYLOAD);
   localparam int ODOM_CNT_W    = $clog2(ODOM_PAYLOAD);
   localparam int JOB_W         = ULTRA_PAYLOAD * 8;

   // Header bytes
   localparam logic [7:0] ULTRA_HDR_FIRST  = 8'hAB;
   localparam logic [7:0] ULTRA_HDR_SECOND = 8'hCD;
   localparam logic [1:0] ULTRA_CAPTURE    = 2'd2;
   localparam logic [2:0] ODOM_CAPTURE     = 3'd4;

   // Frame queue depth
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_MIN_RANGE    = 2'd0;
   localparam logic [1:0] CSR_MAX_RANGE    = 2'd1;
   localparam logic [1:0] CSR_SENSOR_COUNT = 2'd2;

   // Reset values of the configuration registers
   localparam logic [7:0] MIN_RANGE_RESET    = 8'd21;
   localparam logic [7:0] MAX_RANGE_RESET    = 8'd250;
   localparam logic [3:0] SENSOR_COUNT_RESET = 4'd8;

   typedef enum logic {
      KIND_ULTRA = 1'b0,
      KIND_ODOM  = 1'b1
   } kind_type;

   // One finished frame waiting for the back end
   typedef struct packed {
      kind_type           kind;
      logic [JOB_W-1:0]   payload;
   } frame_job_type;

   typedef struct packed {
      logic [7:0] min_range_cm;
      logic [7:0] max_range_cm;
      logic [3:0] sensor_count;
   } cfg_type;

   // Header byte expected at each odometry header position
   function automatic logic [7:0] odom_header_byte(input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0:    b = 8'h43;
         2'd1:    b = 8'h6C;
         2'd2:    b = 8'h60;
         default: b = 8'h03;
      endcase
      return b;
   endfunction

   // Payload position to sensor output index
   function automatic logic [2:0] target_map(input logic [2:0] pos);
      logic [2:0] t;
      case (pos)
         3'd0:    t = 3'd1;
         3'd1:    t = 3'd0;
         3'd2:    t = 3'd7;
         3'd3:    t = 3'd6;
         3'd4:    t = 3'd5;
         3'd5:    t = 3'd4;
         3'd6:    t = 3'd3;
         default: t = 3'd2;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/swfd_front.sv
module swfd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              rx_byte,
   output logic                    push,
   output swfd_pkg::frame_job_type job
);

   logic [1:0]                           ultra_hdr_ff, ultra_hdr_in;
   logic [swfd_pkg::ULTRA_CNT_W-1:0]     ultra_cnt_ff, ultra_cnt_in;
   logic [2:0]                           odom_hdr_ff, odom_hdr_in;
   logic [swfd_pkg::ODOM_CNT_W-1:0]      odom_cnt_ff, odom_cnt_in;
   logic [7:0]                           ultra_buf_ff [swfd_pkg::ULTRA_PAYLOAD];
   logic [7:0]                           odom_buf_ff  [swfd_pkg::ODOM_PAYLOAD];
   logic                                 ultra_wr, odom_wr;

   // Classify the byte and advance both matchers
   always_comb begin
      ultra_hdr_in = ultra_hdr_ff;
      ultra_cnt_in = ultra_cnt_ff;
      odom_hdr_in  = odom_hdr_ff;
      odom_cnt_in  = odom_cnt_ff;
      ultra_wr     = 1'b0;
      odom_wr      = 1'b0;
      push         = 1'b0;
      job          = '0;
      if (accept) begin
         if (ultra_hdr_ff == swfd_pkg::ULTRA_CAPTURE) begin
            // ultrasound payload; odometry matcher holds
            ultra_wr = 1'b1;
            if (ultra_cnt_ff == swfd_pkg::ULTRA_CNT_W'(swfd_pkg::ULTRA_PAYLOAD - 1)) begin
               push     = 1'b1;
               job.kind = swfd_pkg::KIND_ULTRA;
               for (int k = 0; k < swfd_pkg::ULTRA_PAYLOAD - 1; k++) begin
                  job.payload[8*k +: 8] = ultra_buf_ff[k];
               end
               job.payload[8*(swfd_pkg::ULTRA_PAYLOAD-1) +: 8] = rx_byte;
               ultra_hdr_in = 2'd0;
               ultra_cnt_in = '0;
            end else begin
               ultra_cnt_in = ultra_cnt_ff + 1'b1;
            end
         end else begin
            // ultrasound header: a mismatch drops back to the start
            if (rx_byte == ((ultra_hdr_ff == 2'd0) ? swfd_pkg::ULTRA_HDR_FIRST
                                                  : swfd_pkg::ULTRA_HDR_SECOND)) begin
               ultra_hdr_in = ultra_hdr_ff + 1'b1;
               ultra_cnt_in = '0;
            end else begin
               ultra_hdr_in = 2'd0;
            end
            if (odom_hdr_ff != swfd_pkg::ODOM_CAPTURE) begin
               // odometry header: restart on a first-byte match
               if (rx_byte == swfd_pkg::odom_header_byte(odom_hdr_ff[1:0])) begin
                  odom_hdr_in = odom_hdr_ff + 1'b1;
                  odom_cnt_in = '0;
               end else if (rx_byte == swfd_pkg::odom_header_byte(2'd0)) begin
                  odom_hdr_in = 3'd1;
               end else begin
                  odom_hdr_in = 3'd0;
               end
            end else begin
               odom_wr = 1'b1;
               if (odom_cnt_ff == swfd_pkg::ODOM_CNT_W'(swfd_pkg::ODOM_PAYLOAD - 1)) begin
                  push     = 1'b1;
                  job.kind = swfd_pkg::KIND_ODOM;
                  for (int k = 0; k < swfd_pkg::ODOM_PAYLOAD - 1; k++) begin
                     job.payload[8*k +: 8] = odom_buf_ff[k];
                  end
                  job.payload[8*(swfd_pkg::ODOM_PAYLOAD-1) +: 8] = rx_byte;
                  odom_hdr_in = 3'd0;
                  odom_cnt_in = '0;
               end else begin
                  odom_cnt_in = odom_cnt_ff + 1'b1;
               end
            end
         end
      end
   end

   // Hold matcher state
   always_ff @(posedge clock) begin
      if (reset) begin
         ultra_hdr_ff <= 2'd0;
         ultra_cnt_ff <= '0;
         odom_hdr_ff  <= 3'd0;
         odom_cnt_ff  <= '0;
      end else begin
         ultra_hdr_ff <= ultra_hdr_in;
         ultra_cnt_ff <= ultra_cnt_in;
         odom_hdr_ff  <= odom_hdr_in;
         odom_cnt_ff  <= odom_cnt_in;
      end
   end

   // Capture payload bytes
   always_ff @(posedge clock) begin
      if (ultra_wr) begin
         ultra_buf_ff[ultra_cnt_ff] <= rx_byte;
      end
      if (odom_wr) begin
         odom_buf_ff[odom_cnt_ff] <= rx_byte;
      end
   end

endmodule

FILE: rtl/swfd_queue.sv
module swfd_queue #(
   parameter int DEPTH = swfd_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  swfd_pkg::frame_job_type push_job,
   input  logic                    pop,
   output logic                    head_valid,
   output swfd_pkg::frame_job_type head_job,
   output logic                    full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   swfd_pkg::frame_job_type mem_ff [DEPTH];
   logic [PW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]           count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CW'(DEPTH));
   assign head_job   = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the finished frame
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/swfd_back.sv
module swfd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_data,
   input  logic                    head_valid,
   input  swfd_pkg::frame_job_type head_job,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [55:0]             rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);

   swfd_pkg::cfg_type                cfg_ff;
   logic [swfd_pkg::ULTRA_CNT_W-1:0] pos_ff, pos_in;
   logic                             valid_ff, valid_in;
   logic [55:0]                      data_ff, data_in;
   logic                             user_ff, user_in;
   logic                             last_ff, last_in;
   logic                             load;
   logic [7:0]                       echo_cm;
   logic [2:0]                       target;
   logic [15:0]                      rspeed_bits;
   logic [16:0]                      right_ext;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_range_cm <= swfd_pkg::MIN_RANGE_RESET;
         cfg_ff.max_range_cm <= swfd_pkg::MAX_RANGE_RESET;
         cfg_ff.sensor_count <= swfd_pkg::SENSOR_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            swfd_pkg::CSR_MIN_RANGE:    cfg_ff.min_range_cm <= csr_data;
            swfd_pkg::CSR_MAX_RANGE:    cfg_ff.max_range_cm <= csr_data;
            swfd_pkg::CSR_SENSOR_COUNT: cfg_ff.sensor_count <= csr_data[3:0];
            default:                    cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign load        = head_valid && (!valid_ff || rsp_tready);
   assign echo_cm     = head_job.payload[8*pos_ff +: 8];
   assign target      = swfd_pkg::target_map(3'(pos_ff));
   assign rspeed_bits = head_job.payload[31:16];
   assign right_ext   = {rspeed_bits[15], rspeed_bits};

   // Build one result per cycle from the head frame while the output is not stalled
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         data_in  = '0;
         user_in  = head_job.kind;
         if (head_job.kind == swfd_pkg::KIND_ULTRA) begin
            data_in[2:0]  = 3'(pos_ff);
            data_in[5:3]  = target;
            data_in[13:6] = echo_cm;
            data_in[14]   = (echo_cm >= cfg_ff.min_range_cm) &&
                            (echo_cm <= cfg_ff.max_range_cm);
            data_in[15]   = ({1'b0, target} < cfg_ff.sensor_count);
            last_in       = (pos_ff == swfd_pkg::ULTRA_CNT_W'(swfd_pkg::ULTRA_PAYLOAD - 1));
         end else begin
            data_in[31:16] = head_job.payload[15:0];
            data_in[48:32] = 17'd0 - right_ext;
            last_in        = 1'b1;
         end
         if (last_in) begin
            pop    = 1'b1;
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload registers
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: rtl/sensor_and_wheel_frame_deframer.sv
// Channel  Direction  Handshake                Payload
// req      in         req_tvalid/req_tready    rx_byte
// rsp      out        rsp_tvalid/rsp_tready    readings / wheel speeds, tuser kind, tlast
// csr      in         csr_valid/csr_ready      register index and data
//
// One byte is taken per cycle while the frame queue has room; a byte never waits on
// the matchers. A finished ultrasound frame drains as eight results, an odometry frame
// as one result, both through the single output register.
// Reset is synchronous and returns matchers, queue and config registers to their start.
// A stalled rsp side fills the queue, after which req_tready drops.
module sensor_and_wheel_frame_deframer #(
   parameter int QUEUE_DEPTH = swfd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] sensor_position, [5:3] sensor_target, [13:6] echo_cm, [14] in_range,
   // [15] target_enabled, [31:16] left_speed, [48:32] right_speed, [55:49] zero
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic                    accept;
   logic                    push;
   logic                    pop;
   logic                    full;
   logic                    head_valid;
   swfd_pkg::frame_job_type push_job;
   swfd_pkg::frame_job_type head_job;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   swfd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .push    (push),
      .job     (push_job)
   );

   swfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (full)
   );

   swfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: tb/sensor_and_wheel_frame_deframer_tb.sv
module sensor_and_wheel_frame_deframer_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int SHOWN_ERRORS  = 10;

   // Index with no register behind it; writes to it must change nothing
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // Odometry sync bytes, entry 0 first on the wire
   localparam logic [3:0][7:0] ODOM_SYNC = {8'h03, 8'h60, 8'h6C, 8'h43};
   // Sensor output index for each payload position, entry 0 first
   localparam logic [7:0][2:0] SENSOR_REMAP =
      {3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1};

   typedef enum int {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_BURSTY
   } rsp_pattern_type;

   typedef struct {
      swfd_pkg::kind_type kind;
      logic [2:0]  position;
      logic [2:0]  target;
      logic [7:0]  distance;
      logic        in_range;
      logic        enabled;
      logic [15:0] left_speed;
      logic [16:0] right_speed;
      logic        tlast;
   } frame_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [2:0] sensor_position, [5:3] sensor_target, [13:6] echo_cm, [14] in_range,
   // [15] target_enabled, [31:16] left_speed, [48:32] right_speed, [55:49] zero
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;   // [0] kind
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   // Predicted matcher state and register copies
   logic [1:0]  us_hdr_pos;
   logic [3:0]  us_count;
   logic [7:0]  us_buf [8];
   logic [2:0]  od_hdr_pos;
   logic [2:0]  od_count;
   logic [7:0]  od_buf [4];
   logic [7:0]  cfg_min;
   logic [7:0]  cfg_max;
   logic [3:0]  cfg_count;

   frame_result_type expected_readings[$];

   rsp_pattern_type rsp_mode = RSP_ALWAYS;
   bit           req_gaps   = 1'b1;
   int           burst_left = 0;
   int           stall_left = 0;
   int           cycle_count = 0;
   int           mismatches = 0;
   int           bytes_sent = 0;
   int           results_checked = 0;
   int           ultra_frames = 0;
   int           odom_frames = 0;
   int           settings_applied = 0;

   sensor_and_wheel_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, expected_readings.size());
         $display("sensor_and_wheel_frame_deframer_tb NOT OK");
         $finish;
      end
   end

   // Drive the result-side stall pattern
   always @(negedge clock) begin
      case (rsp_mode)
         RSP_ALWAYS: rsp_tready = 1'b1;
         RSP_RANDOM: rsp_tready = ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready = 1'b0;
            end else begin
               rsp_tready = 1'b1;
               if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 24);
            end
         end
      endcase
   end

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got)
         log_mismatch($sformatf("%s expected 0x%0h, got 0x%0h (result %0d)",
                                name, want, got, results_checked));
   endtask

   // Check every accepted result against the oldest prediction
   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            log_mismatch($sformatf("result with none pending, tdata 0x%0h tuser %0b",
                                   rsp_tdata, rsp_tuser));
         end else begin
            want = expected_readings.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_tuser));
            compare_field("sensor_position", 32'(want.position), 32'(rsp_tdata[2:0]));
            compare_field("sensor_target", 32'(want.target), 32'(rsp_tdata[5:3]));
            compare_field("echo_cm", 32'(want.distance), 32'(rsp_tdata[13:6]));
            compare_field("in_range", 32'(want.in_range), 32'(rsp_tdata[14]));
            compare_field("target_enabled", 32'(want.enabled), 32'(rsp_tdata[15]));
            compare_field("left_speed", 32'(want.left_speed), 32'(rsp_tdata[31:16]));
            compare_field("right_speed", 32'(want.right_speed), 32'(rsp_tdata[48:32]));
            compare_field("tdata padding", 32'd0, 32'(rsp_tdata[55:49]));
            compare_field("tlast", 32'(want.tlast), 32'(rsp_tlast));
            results_checked++;
         end
      end
   end

   // Advance the predicted matchers by one byte and queue what it finishes
   task automatic predict_rx_byte(input logic [7:0] b);
      frame_result_type r;
      logic [15:0]   rspeed_bits;
      logic [16:0]   right_ext;
      if (us_hdr_pos >= swfd_pkg::ULTRA_CAPTURE) begin
         // Ultrasound capture: odometry matcher stays frozen
         us_buf[us_count[2:0]] = b;
         us_count = us_count + 4'd1;
         if (us_count >= swfd_pkg::ULTRA_PAYLOAD) begin
            us_hdr_pos = 2'd0;
            us_count   = 4'd0;
            ultra_frames++;
            for (int k = 0; k < 8; k++) begin
               r.kind        = swfd_pkg::KIND_ULTRA;
               r.position    = 3'(k);
               r.target      = SENSOR_REMAP[k];
               r.distance    = us_buf[k];
               r.in_range    = (us_buf[k] >= cfg_min) && (us_buf[k] <= cfg_max);
               r.enabled     = ({1'b0, SENSOR_REMAP[k]} < cfg_count);
               r.left_speed  = 16'd0;
               r.right_speed = 17'd0;
               r.tlast       = (k == 7);
               expected_readings.insert(expected_readings.size(), r);
            end
         end
      end else begin
         // Ultrasound header: a mismatch drops back to the start, no restart
         if (b == (us_hdr_pos == 2'd0 ? swfd_pkg::ULTRA_HDR_FIRST
                                      : swfd_pkg::ULTRA_HDR_SECOND)) begin
            us_hdr_pos = us_hdr_pos + 2'd1;
            if (us_hdr_pos == swfd_pkg::ULTRA_CAPTURE) us_count = 4'd0;
         end else begin
            us_hdr_pos = 2'd0;
         end
         if (od_hdr_pos < swfd_pkg::ODOM_CAPTURE) begin
            // Odometry header: a mismatch restarts on the first sync byte
            if (b == ODOM_SYNC[od_hdr_pos[1:0]]) begin
               od_hdr_pos = od_hdr_pos + 3'd1;
               if (od_hdr_pos == swfd_pkg::ODOM_CAPTURE) od_count = 3'd0;
            end else begin
               od_hdr_pos = (b == ODOM_SYNC[0]) ? 3'd1 : 3'd0;
            end
         end else begin
            od_buf[od_count[1:0]] = b;
            od_count = od_count + 3'd1;
            if (od_count >= swfd_pkg::ODOM_PAYLOAD) begin
               od_hdr_pos = 3'd0;
               od_count   = 3'd0;
               odom_frames++;
               rspeed_bits   = {od_buf[3], od_buf[2]};
               right_ext     = {rspeed_bits[15], rspeed_bits};
               r.kind        = swfd_pkg::KIND_ODOM;
               r.position    = 3'd0;
               r.target      = 3'd0;
               r.distance    = 8'd0;
               r.in_range    = 1'b0;
               r.enabled     = 1'b0;
               r.left_speed  = {od_buf[1], od_buf[0]};
               r.right_speed = 17'd0 - right_ext;
               r.tlast       = 1'b1;
               expected_readings.insert(expected_readings.size(), r);
            end
         end
      end
   endtask

   // Send one byte, opening a random gap when the current burst runs out
   task automatic send_byte(input logic [7:0] b);
      if (burst_left <= 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = 8'($urandom);
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = req_gaps ? $urandom_range(1, 12) : 1000000;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_rx_byte(b);
      bytes_sent++;
      burst_left--;
   endtask

   // Hold the sender until every predicted result has been seen
   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         swfd_pkg::CSR_MIN_RANGE:    cfg_min = value;
         swfd_pkg::CSR_MAX_RANGE:    cfg_max = value;
         swfd_pkg::CSR_SENSOR_COUNT: cfg_count = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
      csr_index = 2'($urandom);
      csr_data  = 8'($urandom);
   endtask

   // Finish any open frame, drain, then load a new register setting
   task automatic apply_setting(input logic [7:0] min_cm, input logic [7:0] max_cm,
                                input logic [7:0] count_byte);
      while (us_hdr_pos >= swfd_pkg::ULTRA_CAPTURE || od_hdr_pos == swfd_pkg::ODOM_CAPTURE)
         send_byte(8'h00);
      wait_all_results();
      write_register(swfd_pkg::CSR_MIN_RANGE, min_cm);
      write_register(swfd_pkg::CSR_MAX_RANGE, max_cm);
      write_register(swfd_pkg::CSR_SENSOR_COUNT, count_byte);
      write_register(CSR_SPARE, 8'($urandom));
      settings_applied++;
   endtask

   // Payload byte biased toward boundaries and sync bytes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
         3:       return cfg_min + 8'($urandom_range(0, 2)) - 8'd1;
         4:       return cfg_max + 8'($urandom_range(0, 2)) - 8'd1;
         5:       return $urandom_range(0, 1) ? swfd_pkg::ULTRA_HDR_FIRST : ODOM_SYNC[0];
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed frames with random content, some noise and broken headers
   task automatic random_traffic(input int count);
      int         start;
      int         cut;
      logic [7:0] b;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               send_byte(swfd_pkg::ULTRA_HDR_FIRST);
               send_byte(swfd_pkg::ULTRA_HDR_SECOND);
               repeat (swfd_pkg::ULTRA_PAYLOAD) send_byte(pick_byte());
            end
            4, 5, 6: begin
               for (int i = 0; i < 4; i++) send_byte(ODOM_SYNC[i]);
               repeat (swfd_pkg::ODOM_PAYLOAD) send_byte(pick_byte());
            end
            7: repeat ($urandom_range(1, 3)) send_byte(pick_byte());
            8: begin
               send_byte(swfd_pkg::ULTRA_HDR_FIRST);
               b = pick_byte();
               if (b == swfd_pkg::ULTRA_HDR_SECOND) b = b ^ 8'h01;
               send_byte(b);
            end
            default: begin
               cut = $urandom_range(1, 3);
               for (int i = 0; i < cut; i++) send_byte(ODOM_SYNC[i]);
               b = pick_byte();
               if (b == ODOM_SYNC[cut]) b = b ^ 8'h10;
               send_byte(b);
            end
         endcase
      end
   endtask

   // Ultrasound frame at reset settings: distance extremes and range edges
   task automatic test_ultra_fields();
      send_byte(swfd_pkg::ULTRA_HDR_FIRST);
      send_byte(swfd_pkg::ULTRA_HDR_SECOND);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(swfd_pkg::MIN_RANGE_RESET - 8'd1);
      send_byte(swfd_pkg::MIN_RANGE_RESET);
      send_byte(swfd_pkg::MAX_RANGE_RESET);
      send_byte(swfd_pkg::MAX_RANGE_RESET + 8'd1);
      send_byte(8'h55);
      send_byte(8'hAA);
      wait_all_results();
   endtask

   // Header corner cases and the interplay of the two matchers
   task automatic test_header_rules();
      // Repeated first ultrasound byte must not restart the header
      send_byte(swfd_pkg::ULTRA_HDR_FIRST);
      send_byte(swfd_pkg::ULTRA_HDR_FIRST);
      send_byte(swfd_pkg::ULTRA_HDR_SECOND);
      send_byte(8'h00);
      // Repeated first odometry byte restarts the header
      send_byte(ODOM_SYNC[0]);
      for (int i = 0; i < 4; i++) send_byte(ODOM_SYNC[i]);
      // Ultrasound header bytes also land in the odometry payload
      send_byte(swfd_pkg::ULTRA_HDR_FIRST);
      send_byte(swfd_pkg::ULTRA_HDR_SECOND);
      // Odometry sync inside the ultrasound payload is ignored
      for (int i = 0; i < 4; i++) send_byte(ODOM_SYNC[i]);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(8'h44);
      // Finish the frozen odometry frame: right raw 0x8000 negates to +32768
      send_byte(8'h00);
      send_byte(8'h80);
      wait_all_results();
   endtask

   // Sweep register settings, each followed by random traffic
   task automatic test_register_settings();
      logic [7:0] min_list [6];
      logic [7:0] max_list [6];
      logic [7:0] cnt_list [6];
      min_list = '{8'd0,   8'd255, 8'd100, 8'($urandom), 8'd40,  8'($urandom)};
      max_list = '{8'd255, 8'd0,   8'd100, 8'($urandom), 8'd200, 8'($urandom)};
      cnt_list = '{8'h08,  8'hF0,  8'h0F,  8'($urandom), 8'h01,  8'h05};
      for (int i = 0; i < 6; i++) begin
         apply_setting(min_list[i], max_list[i], cnt_list[i]);
         rsp_mode = rsp_pattern_type'(i % 3);
         req_gaps = (i % 2 == 0);
         burst_left = 0;
         random_traffic(25);
      end
   endtask

   // Long result stalls fill the frame queue; pause the sender midway
   task automatic test_backpressure();
      rsp_mode = RSP_BURSTY;
      req_gaps = 1'b0;
      burst_left = 0;
      random_traffic(20);
      wait_all_results();
      req_gaps = 1'b1;
      random_traffic(20);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      csr_valid  = 1'b0;
      csr_index  = 2'd0;
      csr_data   = 8'h00;
      us_hdr_pos = 2'd0;
      us_count   = 4'd0;
      od_hdr_pos = 3'd0;
      od_count   = 3'd0;
      foreach (us_buf[i]) us_buf[i] = 8'h00;
      foreach (od_buf[i]) od_buf[i] = 8'h00;
      cfg_min    = swfd_pkg::MIN_RANGE_RESET;
      cfg_max    = swfd_pkg::MAX_RANGE_RESET;
      cfg_count  = swfd_pkg::SENSOR_COUNT_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      rsp_mode = RSP_RANDOM;
      test_ultra_fields();
      test_header_rules();
      test_register_settings();
      test_backpressure();
      wait_all_results();

      $display("Run covered %0d bytes: %0d ultrasound and %0d odometry frames, %0d results",
               bytes_sent, ultra_frames, odom_frames, results_checked);
      $display("Register settings loaded: %0d, field mismatches: %0d",
               settings_applied, mismatches);
      if (mismatches == 0) begin
         $display("sensor_and_wheel_frame_deframer_tb OK");
      end else begin
         $display("sensor_and_wheel_frame_deframer_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/swfd_pkg.sv
rtl/swfd_front.sv
rtl/swfd_queue.sv
rtl/swfd_back.sv
rtl/sensor_and_wheel_frame_deframer.sv
tb/sensor_and_wheel_frame_deframer_tb.sv
